@@ src/rcd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcd_pkg
// shared types and constants of the chunk stream deframer
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int STREAM_SLOTS = 8;
  localparam int SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

  localparam logic [2:0] PH_BASIC       = 3'd0;
  localparam logic [2:0] PH_BASIC_ONE   = 3'd1;
  localparam logic [2:0] PH_BASIC_TWO_A = 3'd2;
  localparam logic [2:0] PH_BASIC_TWO_B = 3'd3;
  localparam logic [2:0] PH_MSG_HDR     = 3'd4;
  localparam logic [2:0] PH_EXT         = 3'd5;
  localparam logic [2:0] PH_PAYLOAD     = 3'd6;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_FULL    = 2'd2;

  localparam logic [23:0] TS_MARKER = 24'hFFFFFF;
  localparam logic [16:0] CHUNK_MIN = 17'd128;
  localparam logic [16:0] CHUNK_MAX = 17'd65536;

  localparam logic [7:0] MT_SET_CHUNK = 8'd1;
  localparam logic [7:0] MT_ABORT     = 8'd2;

  // one result word
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic [16:0] chunk_stream_id;
    logic [31:0] message_stream_id;
    logic [7:0]  message_type;
    logic [31:0] message_timestamp;
    logic [23:0] message_length;
    logic        last_of_message;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [16:0] sid;
    logic [31:0] ts;
    logic [31:0] delta;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] msid;
    logic        ext;
    logic [23:0] rem;
  } slot_t;

endpackage

@@ src/rcd_out_reg.sv @@
// ----------------------------------------------------------------------------
// rcd_out_reg
// result register with skid stage, full throughput valid/ready
// ----------------------------------------------------------------------------
module rcd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rcd_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output rcd_pkg::result_t out_data
);
  import rcd_pkg::*;

  logic    main_vld_r, skid_vld_r;
  result_t main_r, skid_r;

  assign can_push  = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!main_vld_r || out_ready) begin
        if (skid_vld_r) begin
          main_r     <= skid_r;
          main_vld_r <= 1'b1;
          skid_vld_r <= 1'b0;
          if (push) begin
            skid_r     <= push_data;
            skid_vld_r <= 1'b1;
          end
        end else begin
          main_vld_r <= push;
          if (push) main_r <= push_data;
        end
      end else if (push) begin
        skid_r     <= push_data;
        skid_vld_r <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) skid_vld_r |-> main_vld_r)
    else $error("skid full with empty main");
  assert property (@(posedge clk) disable iff (!rst_n)
    (main_vld_r && !out_ready) |=> main_vld_r)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> can_push)
    else $error("push into full skid");

endmodule

@@ src/rtmp_chunk_deframer.sv @@
// ----------------------------------------------------------------------------
// rtmp_chunk_deframer
// rtmp chunk stream deframer, one received byte per word
// ----------------------------------------------------------------------------
// Takes one byte of the connection per accepted word and returns at most one
// result word per byte: a payload byte with its message fields, an empty
// message marker, or an error. Every byte is handled in the cycle it is
// accepted, so the block sustains one byte per clock; the input stalls only
// when both the result register and its skid stage are full. Per chunk stream
// state lives in STREAM_SLOTS flip-flop slots found by parallel compare;
// a new stream takes the lowest free slot and slots are never freed.
// Each result is registered in the result register before it reaches the output.
module rtmp_chunk_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_byte,
  output logic [16:0] out_chunk_stream_id,
  output logic [31:0] out_message_stream_id,
  output logic [7:0]  out_message_type,
  output logic [31:0] out_message_timestamp,
  output logic [23:0] out_message_length,
  output logic        out_last_of_message,
  output logic [1:0]  out_error_code
);
  import rcd_pkg::*;

  // parse state
  slot_t       slot_r [STREAM_SLOTS];
  slot_t       slot_nxt [STREAM_SLOTS];
  logic [16:0] chunk_size_r, chunk_size_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [16:0] pend_r, pend_nxt;
  logic [16:0] cleft_r, cleft_nxt;
  logic [31:0] cword_r, cword_nxt;
  logic [2:0]  ccnt_r, ccnt_nxt;

  logic    accept, push, can_push;
  result_t res;

  assign in_ready = can_push;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [7:0]  b;
    logic        do_basic, do_after, do_finish, found, free_found;
    logic [16:0] csid;
    logic [SLOT_W-1:0] s, hit, fr;
    logic [3:0]  hlen, i;
    logic [31:0] fs;
    logic [23:0] t, r;
    logic        last;
    logic [31:0] cw;
    logic [30:0] v;
    b = in_rx_byte;
    slot_nxt = slot_r;
    chunk_size_nxt = chunk_size_r;
    phase_nxt = phase_r;
    hcnt_nxt = hcnt_r;
    shift_nxt = shift_r;
    cur_nxt = cur_r;
    fmt_nxt = fmt_r;
    pend_nxt = pend_r;
    cleft_nxt = cleft_r;
    cword_nxt = cword_r;
    ccnt_nxt = ccnt_r;
    push = 1'b0;
    res = '0;
    do_basic = 1'b0;
    do_after = 1'b0;
    do_finish = 1'b0;
    csid = '0;
    found = 1'b0;
    free_found = 1'b0;
    hit = '0;
    fr = '0;
    s = cur_r;
    hlen = 4'd0;
    i = hcnt_r;
    fs = shift_r;
    t = '0;
    r = '0;
    last = 1'b0;
    cw = cword_r;
    v = '0;

    case (phase_r)
      PH_BASIC: begin
        fmt_nxt = b[7:6];
        if (b[5:0] == 6'd0) phase_nxt = PH_BASIC_ONE;
        else if (b[5:0] == 6'd1) phase_nxt = PH_BASIC_TWO_A;
        else begin
          do_basic = 1'b1;
          csid = {11'd0, b[5:0]};
        end
      end
      PH_BASIC_ONE: begin
        do_basic = 1'b1;
        csid = {9'd0, b} + 17'd64;
      end
      PH_BASIC_TWO_A: begin
        pend_nxt = {9'd0, b};
        phase_nxt = PH_BASIC_TWO_B;
      end
      PH_BASIC_TWO_B: begin
        do_basic = 1'b1;
        csid = {1'b0, b, pend_r[7:0]} + 17'd64;
      end
      PH_MSG_HDR: begin
        if (i < 4'd7) fs = {shift_r[23:0], b};
        else fs = {b, shift_r[31:8]};
        if (i == 4'd2) begin
          t = fs[23:0];
          slot_nxt[s].ext = (t == TS_MARKER);
          if (fmt_r == 2'd0) begin
            if (t != TS_MARKER) slot_nxt[s].ts = {8'd0, t};
            slot_nxt[s].delta = '0;
          end else if (t != TS_MARKER) begin
            slot_nxt[s].delta = {8'd0, t};
            slot_nxt[s].ts = slot_r[s].ts + {8'd0, t};
          end
          fs = '0;
        end else if (i == 4'd5) begin
          slot_nxt[s].len = fs[23:0];
          fs = '0;
        end else if (i == 4'd6) begin
          slot_nxt[s].mtype = fs[7:0];
          fs = '0;
        end else if (i == 4'd10) begin
          slot_nxt[s].msid = fs;
          fs = '0;
        end
        shift_nxt = fs;
        hcnt_nxt = i + 4'd1;
        hlen = (fmt_r == 2'd0) ? 4'd11 : (fmt_r == 2'd1) ? 4'd7 : 4'd3;
        if (hcnt_nxt >= hlen) do_after = 1'b1;
      end
      PH_EXT: begin
        fs = {shift_r[23:0], b};
        hcnt_nxt = hcnt_r + 4'd1;
        shift_nxt = fs;
        if (hcnt_nxt >= 4'd4) begin
          if (fmt_r == 2'd0) slot_nxt[s].ts = fs;
          else if (fmt_r != 2'd3) begin
            slot_nxt[s].delta = fs;
            slot_nxt[s].ts = slot_r[s].ts + fs;
          end else if (slot_r[s].rem == 24'd0) slot_nxt[s].delta = fs;
          shift_nxt = '0;
          do_finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (slot_r[s].rem == 24'd0 || cleft_r == 17'd0) phase_nxt = PH_BASIC;
        else begin
          if (slot_r[s].msid == 32'd0 && (slot_r[s].mtype == MT_SET_CHUNK ||
              slot_r[s].mtype == MT_ABORT) && ccnt_r < 3'd4) begin
            cw = {cword_r[23:0], b};
            cword_nxt = cw;
            ccnt_nxt = ccnt_r + 3'd1;
          end
          r = slot_r[s].rem - 24'd1;
          slot_nxt[s].rem = r;
          cleft_nxt = cleft_r - 17'd1;
          last = (r == 24'd0);
          push = 1'b1;
          res.payload_byte = b;
          res.has_byte = 1'b1;
          res.chunk_stream_id = slot_r[s].sid;
          res.message_stream_id = slot_r[s].msid;
          res.message_type = slot_r[s].mtype;
          res.message_timestamp = slot_r[s].ts;
          res.message_length = slot_r[s].len;
          res.last_of_message = last;
          res.error_code = ERR_NONE;
          // control message completes on its last byte
          if (last && slot_r[s].msid == 32'd0 && ccnt_nxt >= 3'd4) begin
            if (slot_r[s].mtype == MT_SET_CHUNK) begin
              v = cw[30:0];
              if (v < 31'(CHUNK_MIN)) chunk_size_nxt = CHUNK_MIN;
              else if (v > 31'(CHUNK_MAX)) chunk_size_nxt = CHUNK_MAX;
              else chunk_size_nxt = v[16:0];
            end else if (slot_r[s].mtype == MT_ABORT) begin
              for (int k = 0; k < STREAM_SLOTS; k++)
                if (slot_r[k].valid && {15'd0, slot_r[k].sid} == cw)
                  slot_nxt[k].rem = '0;
            end
          end
          if (cleft_nxt == 17'd0 || last) phase_nxt = PH_BASIC;
        end
      end
      default: phase_nxt = PH_BASIC;
    endcase

    // basic header done: find or allocate a slot, or report an error
    if (do_basic) begin
      pend_nxt = csid;
      for (int k = STREAM_SLOTS - 1; k >= 0; k--) begin
        if (slot_r[k].valid && slot_r[k].sid == csid) begin
          found = 1'b1;
          hit = SLOT_W'(k);
        end
        if (!slot_r[k].valid) begin
          free_found = 1'b1;
          fr = SLOT_W'(k);
        end
      end
      if (!found && (fmt_nxt != 2'd0 || !free_found)) begin
        push = 1'b1;
        res.chunk_stream_id = csid;
        res.error_code = (fmt_nxt != 2'd0) ? ERR_UNKNOWN : ERR_FULL;
        phase_nxt = PH_BASIC;
      end else begin
        s = found ? hit : fr;
        if (!found) begin
          slot_nxt[s] = '0;
          slot_nxt[s].valid = 1'b1;
          slot_nxt[s].sid = csid;
        end
        cur_nxt = s;
        hcnt_nxt = '0;
        shift_nxt = '0;
        if (fmt_nxt != 2'd3) phase_nxt = PH_MSG_HDR;
        else do_after = 1'b1;
      end
    end

    if (do_after) begin
      if (slot_nxt[s].ext) begin
        phase_nxt = PH_EXT;
        hcnt_nxt = '0;
        shift_nxt = '0;
      end else do_finish = 1'b1;
    end

    if (do_finish) begin
      if (fmt_nxt != 2'd3 || slot_nxt[s].rem == 24'd0) begin
        if (fmt_nxt == 2'd3) slot_nxt[s].ts = slot_nxt[s].ts + slot_nxt[s].delta;
        slot_nxt[s].rem = slot_nxt[s].len;
        ccnt_nxt = '0;
        cword_nxt = '0;
      end
      r = slot_nxt[s].rem;
      cleft_nxt = ({1'b0, r} < {8'd0, chunk_size_r}) ? r[16:0] : chunk_size_r;
      if (r == 24'd0) begin
        phase_nxt = PH_BASIC;
        push = 1'b1;
        res.chunk_stream_id = slot_nxt[s].sid;
        res.message_stream_id = slot_nxt[s].msid;
        res.message_type = slot_nxt[s].mtype;
        res.message_timestamp = slot_nxt[s].ts;
        res.message_length = slot_nxt[s].len;
        res.last_of_message = 1'b1;
      end else phase_nxt = PH_PAYLOAD;
    end

    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STREAM_SLOTS; k++) slot_r[k] <= '0;
      chunk_size_r <= CHUNK_MIN;
      phase_r <= PH_BASIC;
      hcnt_r <= '0;
      shift_r <= '0;
      cur_r <= '0;
      fmt_r <= '0;
      pend_r <= '0;
      cleft_r <= '0;
      cword_r <= '0;
      ccnt_r <= '0;
    end else if (accept) begin
      slot_r <= slot_nxt;
      chunk_size_r <= chunk_size_nxt;
      phase_r <= phase_nxt;
      hcnt_r <= hcnt_nxt;
      shift_r <= shift_nxt;
      cur_r <= cur_nxt;
      fmt_r <= fmt_nxt;
      pend_r <= pend_nxt;
      cleft_r <= cleft_nxt;
      cword_r <= cword_nxt;
      ccnt_r <= ccnt_nxt;
    end
  end

  result_t od;

  rcd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (od)
  );

  assign out_payload_byte      = od.payload_byte;
  assign out_has_byte          = od.has_byte;
  assign out_chunk_stream_id   = od.chunk_stream_id;
  assign out_message_stream_id = od.message_stream_id;
  assign out_message_type      = od.message_type;
  assign out_message_timestamp = od.message_timestamp;
  assign out_message_length    = od.message_length;
  assign out_last_of_message   = od.last_of_message;
  assign out_error_code        = od.error_code;

  // chunk size always stays in the legal window
  assert property (@(posedge clk) disable iff (!rst_n)
    chunk_size_r >= CHUNK_MIN && chunk_size_r <= CHUNK_MAX)
    else $error("chunk size out of range");
  // payload phase never runs with a chunk budget above chunk size
  assert property (@(posedge clk) disable iff (!rst_n)
    cleft_r <= chunk_size_r || phase_r != PH_PAYLOAD)
    else $error("chunk budget exceeds chunk size");
  // control capture never exceeds four bytes
  assert property (@(posedge clk) disable iff (!rst_n) ccnt_r <= 3'd4)
    else $error("control capture overrun");

endmodule
